### rtl/arp_lfu_pkg.sv
// Package for the ARP cache table with least-frequently-used replacement.
// Holds the command and outcome codes and the request and response payload types.
// No dependencies.
package arp_lfu_pkg;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned SLOT_W = 3;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_NONE     = 2'd0,
    OUT_FREE     = 2'd1,
    OUT_REPLACED = 2'd2,
    OUT_DELETED  = 2'd3
  } outcome_e;

  typedef struct packed {
    cmd_e             command;
    logic [MAC_W-1:0] mac_key;
    logic [IP_W-1:0]  ip_value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [IP_W-1:0]   ip_result;
    logic [SLOT_W-1:0] slot_used;
    outcome_e          outcome;
  } rsp_t;

endpackage

### rtl/arp_cache_lfu_table_core.sv
// A taken request walks the table, then passes a drain step, an update step, a write step when
// an append writes a new entry, and a response step; the walk reads one entry per cycle from the
// single-port entry memory. The next request is taken only once the last has left the response
// step; the response sits in an output register, so the next request is taken while it waits.
// Reset clears the per-entry valid bits at once, so every entry reads as free and all zero;
// the entry memory itself is not cleared and no clearing pass is needed. Uses arp_lfu_pkg.
module arp_cache_lfu_table_core
  import arp_lfu_pkg::*;
#(
  parameter int unsigned ENTRIES        = 8,
  parameter int unsigned USE_COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  // Each memory word is {mac, ip, use count}.
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned EW = MAC_W + IP_W + USE_COUNT_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPD,
    S_WRITE,
    S_RESP
  } state_e;

  state_e state_q;
  req_t   item_q;

  // Entry memory with registered read data, plus one valid bit per entry.
  logic [EW-1:0]      mem_q [ENTRIES];
  logic [EW-1:0]      rd_data_q;
  logic               rd_vld_q;
  logic [ENTRIES-1:0] vld_q;
  logic               mem_re;
  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  logic [EW-1:0]      mem_wd;

  // Walk counter and the index of the read that is in flight.
  logic [IW-1:0] cnt_q;
  logic          rd_pend_q;
  logic [IW-1:0] rd_idx_q;

  // What the walk has found so far.
  logic                      hit_q;
  logic [IW-1:0]             hit_idx_q;
  logic [IP_W-1:0]           hit_ip_q;
  logic [USE_COUNT_BITS-1:0] hit_use_q;
  logic                      free_q;
  logic [IW-1:0]             free_idx_q;
  logic [IW-1:0]             lu_idx_q;
  logic [USE_COUNT_BITS-1:0] lu_use_q;

  logic out_valid_q;
  rsp_t out_q;

  // Decoded view of the entry that just came back from memory.
  logic [MAC_W-1:0]          rd_mac;
  logic [IP_W-1:0]           rd_ip;
  logic [USE_COUNT_BITS-1:0] rd_use;
  logic [USE_COUNT_BITS-1:0] rd_use_inc;
  logic [USE_COUNT_BITS-1:0] eff_use;
  logic                      counts_use;
  logic                      is_cmd;
  logic                      is_match;
  logic                      is_free;
  logic                      is_less;

  logic          need_wr;
  logic [IW-1:0] w_idx;
  rsp_t          res;
  logic [IW+SLOT_W-1:0] slot_wide;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An entry whose valid bit is clear reads as all zero, which marks it free.
  always_comb begin
    rd_mac = rd_vld_q ? rd_data_q[EW-1 -: MAC_W] : '0;
    rd_ip  = rd_vld_q ? rd_data_q[USE_COUNT_BITS +: IP_W] : '0;
    rd_use = rd_vld_q ? rd_data_q[USE_COUNT_BITS-1:0] : '0;
    rd_use_inc = (rd_use == '1) ? rd_use : rd_use + 1'b1;
    counts_use = (item_q.command == CMD_LOOKUP) || (item_q.command == CMD_APPEND);
    is_cmd     = counts_use || (item_q.command == CMD_DELETE);
    // Only the first match counts; a zero key is kept from matching, since free slots hold zero.
    is_match   = rd_pend_q && is_cmd && (item_q.mac_key != '0) &&
                 (rd_mac == item_q.mac_key) && !hit_q;
    // The matched entry's use is counted before the least-used search sees it.
    eff_use    = (is_match && counts_use) ? rd_use_inc : rd_use;
    is_free    = rd_pend_q && (rd_mac == '0) && !free_q;
    // Strict less-than keeps the lowest index on a tie.
    is_less    = rd_pend_q && ((rd_idx_q == '0) || (eff_use < lu_use_q));
  end

  // An append writes a new entry unless the exact pair is already present.
  always_comb begin
    need_wr = (item_q.command == CMD_APPEND) && (item_q.mac_key != '0) &&
              (!hit_q || (hit_ip_q != item_q.ip_value));
    w_idx   = free_q ? free_idx_q : lu_idx_q;
  end

  // Response fields, formed from the walk results once all writes are done.
  always_comb begin
    res       = '0;
    res.found = hit_q;
    if ((item_q.command == CMD_LOOKUP) && hit_q) begin
      res.ip_result = hit_ip_q;
    end
    if (need_wr) begin
      slot_wide   = {{SLOT_W{1'b0}}, w_idx};
      res.outcome = free_q ? OUT_FREE : OUT_REPLACED;
    end else begin
      slot_wide = hit_q ? {{SLOT_W{1'b0}}, hit_idx_q} : '0;
      if ((item_q.command == CMD_DELETE) && hit_q) begin
        res.outcome = OUT_DELETED;
      end
    end
    res.slot_used = slot_wide[SLOT_W-1:0];
  end

  // Memory port control. The hit entry is updated first; a new pair is written after it,
  // so when the least-used victim is the hit entry the new pair wins with a zero count.
  always_comb begin
    mem_re = (state_q == S_SCAN);
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    case (state_q)
      S_UPD: begin
        mem_we = hit_q;
        mem_wa = hit_idx_q;
        if (item_q.command != CMD_DELETE) begin
          mem_wd = {item_q.mac_key, hit_ip_q, hit_use_q};
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_wa = w_idx;
        mem_wd = {item_q.mac_key, item_q.ip_value, {USE_COUNT_BITS{1'b0}}};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_ip_q    <= '0;
      hit_use_q   <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      lu_idx_q    <= '0;
      lu_use_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rd_pend_q <= mem_re;
      rd_idx_q  <= cnt_q;
      if (mem_re) begin
        rd_vld_q <= vld_q[cnt_q];
      end
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end

      if (is_match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
        hit_ip_q  <= rd_ip;
        hit_use_q <= eff_use;
      end
      if (is_free) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (is_less) begin
        lu_idx_q <= rd_idx_q;
        lu_use_q <= eff_use;
      end

      // The response step refills the register itself when it frees up in the same cycle.
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            cnt_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_q == LAST_IDX) begin
            state_q <= S_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          state_q <= need_wr ? S_WRITE : S_RESP;
        end
        S_WRITE: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The table is never written while it is being walked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_DRAIN) |-> !mem_we)
    else $error("entry memory written during the table walk");

  // A new response only appears after the response step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESP))
    else $error("response appeared outside the response step");

  // A delete outcome always reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.outcome != OUT_DELETED || out_data_o.found))
    else $error("delete reported without a matching entry");

  // A taken request starts the walk at entry zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SCAN && cnt_q == '0))
    else $error("table walk did not start at entry zero");

  // The second write of an append only follows an update step that asked for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> ($past(state_q == S_UPD) && need_wr))
    else $error("entry write without an append that needs it");

endmodule

### test/arp_cache_lfu_table_core_tb.sv
// Self-checking testbench for the ARP cache table with least-frequently-used replacement.
// A table model inside the bench predicts every response; directed and random traffic run
// under random idling on both sides. Depends on arp_lfu_pkg and arp_cache_lfu_table_core.
module arp_cache_lfu_table_core_tb;
  import arp_lfu_pkg::*;

  // The block under test runs with its default table size and a narrow use counter, so
  // that saturation is reached within a short run.
  localparam int unsigned ENTRIES     = 8;
  localparam int unsigned USE_BITS    = 4;
  // One more lookup than it takes to reach the counter maximum, plus a few.
  localparam int unsigned SAT_LOOKUPS = (1 << USE_BITS) + 4;
  localparam int unsigned RANDOM_ITEMS = 680;
  // Long receiver hold-off used to back the table up into its input.
  localparam int unsigned HOLD_CYCLES = 400;
  // The tail wait outlasts the longest single request, an append that writes a new entry.
  localparam int unsigned TAIL_CYCLES = 3 * (ENTRIES + 5);
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;

  always #5 clk_i = ~clk_i;

  arp_cache_lfu_table_core #(
    .ENTRIES        (ENTRIES),
    .USE_COUNT_BITS (USE_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------------------
  // Table model. It mirrors the entries of the block: MAC, IP and a saturating use count.
  // A MAC of zero marks a free slot, and a free slot never matches a key.
  // ---------------------------------------------------------------------------------------
  logic [MAC_W-1:0]    tbl_mac  [ENTRIES];
  logic [IP_W-1:0]     tbl_ip   [ENTRIES];
  logic [USE_BITS-1:0] tbl_uses [ENTRIES];

  // Responses predicted for accepted requests, oldest first.
  rsp_t answers_due[$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Sender idling: bursts of random length separated by gaps of random length, bounded by gap_max.
  int unsigned burst_left = 0;
  int unsigned gap_max    = 0;
  // Receiver idling: runs of stall or no stall; stall_pct sets how often a run stalls.
  int unsigned stall_pct  = 0;
  int unsigned stall_run  = 0;
  // A test asks for a long hold-off by bumping hold_reqs; the receiver counts it out.
  int unsigned hold_reqs  = 0;
  int unsigned hold_acks  = 0;
  int unsigned hold_left  = 0;

  // Key and address pools for the random traffic, so that lookups hit and appends repeat.
  logic [MAC_W-1:0] mac_pool [8];
  logic [IP_W-1:0]  ip_pool  [4];

  function automatic void bump_use(int idx);
    if (tbl_uses[idx] != {USE_BITS{1'b1}}) begin
      tbl_uses[idx] = tbl_uses[idx] + 1'b1;
    end
  endfunction

  // Applies one request to the table model and returns the response it must produce.
  function automatic rsp_t resolve_request(req_t req);
    rsp_t rsp;
    int   hit;
    int   slot;
    rsp  = '0;
    hit  = -1;
    slot = -1;
    // First occupied entry with this MAC; a zero key can only meet free slots.
    if (req.mac_key != '0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && tbl_mac[i] == req.mac_key) begin
          hit = i;
        end
      end
    end
    case (req.command)
      CMD_LOOKUP: begin
        if (hit >= 0) begin
          bump_use(hit);
          rsp.found     = 1'b1;
          rsp.ip_result = tbl_ip[hit];
          rsp.slot_used = SLOT_W'(hit);
        end
      end
      CMD_APPEND: begin
        if (req.mac_key != '0) begin
          // The presence check counts as a use of the matched entry.
          if (hit >= 0) begin
            bump_use(hit);
            rsp.found     = 1'b1;
            rsp.slot_used = SLOT_W'(hit);
          end
          // A new pair, or a known MAC with a new IP, is written to a slot of its own.
          if (hit < 0 || tbl_ip[hit] != req.ip_value) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot < 0 && tbl_mac[i] == '0) begin
                slot = i;
              end
            end
            if (slot >= 0) begin
              rsp.outcome = OUT_FREE;
            end else begin
              // Smallest use count wins; the strict compare keeps the lowest index on a tie.
              slot = 0;
              for (int i = 1; i < ENTRIES; i++) begin
                if (tbl_uses[i] < tbl_uses[slot]) begin
                  slot = i;
                end
              end
              rsp.outcome = OUT_REPLACED;
            end
            tbl_mac[slot]  = req.mac_key;
            tbl_ip[slot]   = req.ip_value;
            tbl_uses[slot] = '0;
            rsp.slot_used  = SLOT_W'(slot);
          end
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          tbl_mac[hit]  = '0;
          tbl_ip[hit]   = '0;
          tbl_uses[hit] = '0;
          rsp.found     = 1'b1;
          rsp.slot_used = SLOT_W'(hit);
          rsp.outcome   = OUT_DELETED;
        end
      end
      default: begin
        // The unused command leaves the table alone and answers all zero.
      end
    endcase
    return rsp;
  endfunction

  function automatic logic [MAC_W-1:0] fresh_mac();
    logic [MAC_W-1:0] mac;
    mac[MAC_W-1:32] = 16'($urandom_range(0, 16'hFFFF));
    mac[31:0]       = $urandom;
    return mac;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s at cycle %0d: got %0h, expected %0h", what, cycle_cnt, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Request side. Called at a rising edge; returns at the edge where the transfer happened.
  // Valid is lowered only when a gap starts, and a gap always waits for a clock edge, so valid
  // never gets two assignments in one time step. The payload holds while the block stalls.
  // ---------------------------------------------------------------------------------------
  task automatic send_request(cmd_e cmd, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip);
    req_t req;
    req.command  = cmd;
    req.mac_key  = mac;
    req.ip_value = ip;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    // Outputs read right after the edge still hold their pre-edge values.
    do @(posedge clk_i); while (in_stall_o);
    answers_due.push_back(resolve_request(req));
  endtask

  // Stops offering requests until every predicted response has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    // The queue is looked at on the falling edge, away from the monitor's pops.
    do @(negedge clk_i); while (answers_due.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic send_random();
    int unsigned      pick;
    cmd_e             cmd;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    // Now and then a pool entry is replaced, which pushes the table into replacement.
    if ($urandom_range(0, 9) == 0) begin
      mac_pool[$urandom_range(0, 7)] = fresh_mac();
    end
    if ($urandom_range(0, 19) == 0) begin
      ip_pool[$urandom_range(0, 3)] = $urandom;
    end
    mac = mac_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 19))
      0:       mac = '0;
      1, 2:    mac = fresh_mac();
      default: ;
    endcase
    ip   = ($urandom_range(0, 9) < 6) ? ip_pool[$urandom_range(0, 3)] : $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      cmd = CMD_LOOKUP;
    end else if (pick < 75) begin
      cmd = CMD_APPEND;
    end else if (pick < 90) begin
      cmd = CMD_DELETE;
    end else if (pick < 95) begin
      cmd = CMD_NONE;
    end else begin
      // Noise: any command with a key that is almost surely absent.
      cmd = cmd_e'($urandom_range(0, 3));
      mac = fresh_mac();
    end
    send_request(cmd, mac, ip);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Misses on an empty table, the zero key, the unused command, field extremes, duplicate
  // MACs and deletion.
  task automatic test_basic_commands();
    logic [MAC_W-1:0] mac_max;
    mac_max   = '1;
    gap_max   = 3;
    stall_pct = 30;
    send_request(CMD_LOOKUP, mac_max, '1);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_DELETE, 48'h5, '0);
    send_request(CMD_NONE, mac_max, '1);
    // An append with a zero MAC is ignored.
    send_request(CMD_APPEND, '0, '1);
    send_request(CMD_APPEND, mac_max, '1);
    send_request(CMD_APPEND, 48'h1, '0);
    send_request(CMD_LOOKUP, mac_max, '0);
    // The exact pair is already there: no entry is written, only its use is counted.
    send_request(CMD_APPEND, mac_max, '1);
    // Same MAC, other IP: a second entry appears and lookups keep returning the first.
    send_request(CMD_APPEND, mac_max, 32'h1);
    send_request(CMD_LOOKUP, mac_max, '0);
    send_request(CMD_DELETE, mac_max, '0);
    send_request(CMD_LOOKUP, mac_max, '0);
    // The freed slot holds MAC zero and still must not match a zero key.
    send_request(CMD_LOOKUP, '0, '0);
    wait_drained();
  endtask

  // Fills the table and then forces replacement, including ties between unused entries.
  task automatic test_replacement();
    gap_max   = 2;
    stall_pct = 20;
    for (int i = 0; i < 7; i++) begin
      send_request(CMD_APPEND, 48'hA0_0000_0000 + 48'(i), $urandom);
    end
    send_request(CMD_LOOKUP, 48'hA0_0000_0006, '0);
    send_request(CMD_APPEND, 48'hA0_0000_0007, $urandom);
    send_request(CMD_APPEND, 48'hA0_0000_0008, $urandom);
    wait_drained();
  endtask

  // Drives one entry's use count past its maximum, then appends to a full table so that
  // a wrapped counter would show up as the wrong victim. Runs with no idling at all.
  task automatic test_use_saturation();
    logic [MAC_W-1:0] hot_mac;
    gap_max   = 0;
    stall_pct = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_mac[i] == '0) begin
        send_request(CMD_APPEND, fresh_mac(), $urandom);
      end
    end
    hot_mac = tbl_mac[0];
    // Every other entry gets more uses than a wrapped counter would show.
    repeat (8) begin
      for (int i = 1; i < ENTRIES; i++) begin
        send_request(CMD_LOOKUP, tbl_mac[i], $urandom);
      end
    end
    repeat (SAT_LOOKUPS) send_request(CMD_LOOKUP, hot_mac, $urandom);
    repeat (2) send_request(CMD_APPEND, fresh_mac(), $urandom);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the block
  // fills its output register and then stalls its input.
  task automatic test_output_hold();
    gap_max   = 0;
    stall_pct = 10;
    hold_reqs <= hold_reqs + 1;
    repeat (30) send_random();
    wait_drained();
  endtask

  // Bulk random traffic in phases of different idling on both sides.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_max = 0; stall_pct = 0;  end
        1:       begin gap_max = 3; stall_pct = 30; end
        2:       begin gap_max = 8; stall_pct = 60; end
        default: begin gap_max = 2; stall_pct = 85; end
      endcase
      repeat (RANDOM_ITEMS / 4) send_random();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------------------
  // Response side: stall pattern of its own, plus the long hold-off on request.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_reqs != hold_acks) begin
      hold_acks   <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (stall_run == 0) begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      stall_run   <= $urandom_range(1, 6);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // Each response transfer is checked, field by field, against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) begin
        report_mismatch("response with none pending", 64'(out_data_o), '0);
      end else begin
        want = answers_due.pop_front();
        if (out_data_o.found !== want.found) begin
          report_mismatch("found", 64'(out_data_o.found), 64'(want.found));
        end
        if (out_data_o.ip_result !== want.ip_result) begin
          report_mismatch("ip_result", 64'(out_data_o.ip_result), 64'(want.ip_result));
        end
        if (out_data_o.slot_used !== want.slot_used) begin
          report_mismatch("slot_used", 64'(out_data_o.slot_used), 64'(want.slot_used));
        end
        if (out_data_o.outcome !== want.outcome) begin
          report_mismatch("outcome", 64'(out_data_o.outcome), 64'(want.outcome));
        end
      end
    end
  end

  // A run that never drains is cut off here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_mac[i]  = '0;
      tbl_ip[i]   = '0;
      tbl_uses[i] = '0;
    end
    // The pools start with the field extremes and change as the random traffic runs.
    mac_pool[0] = '1;
    mac_pool[1] = 48'h1;
    for (int i = 2; i < 8; i++) begin
      mac_pool[i] = fresh_mac();
    end
    ip_pool[0] = '1;
    ip_pool[1] = '0;
    ip_pool[2] = $urandom;
    ip_pool[3] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_replacement();
    test_use_saturation();
    test_output_hold();
    test_random_traffic();

    // Anything the block sends after the last prediction is caught by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
